@@ rtl/aoc_pkg.sv @@
package aoc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_TIME_STEP  = 3'd0;
  localparam logic [2:0] REG_RELAX_LEN  = 3'd1;
  localparam logic [2:0] REG_FAR_VALUE  = 3'd2;
  localparam logic [2:0] REG_SCHEME     = 3'd3;
  localparam logic [2:0] REG_MASS_FLUX  = 3'd4;

  localparam logic [1:0] SCHEME_EULER       = 2'd0;
  localparam logic [1:0] SCHEME_BACKWARD    = 2'd1;
  localparam logic [1:0] SCHEME_UNSUPPORTED = 2'd2;

  localparam logic [30:0] SAT31 = 31'h7fffffff;

  typedef struct packed {
    logic [30:0] time_step;
    logic [30:0] relax_length;
    logic signed [31:0] far_value;
    logic [1:0]  time_scheme;
    logic        mass_flux_mode;
  } cfg_t;

endpackage

@@ rtl/advective_outflow_coefficients_core.sv @@
// Advective outflow coefficients: one boundary face (or vector component) per
// request in, one result per request out, one request per cycle sustained while
// the output is not stalled. The datapath is three chained 64-stage bit-per-stage
// division pipelines (speed, relaxation coefficient, then reference value terms
// and value fraction side by side) plus register stages A, C, D, E and the output
// stage around them. m_tready low with a result waiting freezes the whole
// pipeline; s_tready follows the output slot being free.
// Configuration must be written only while the pipeline is empty.
module advective_outflow_coefficients_core #(
  parameter int FRAC_BITS = aoc_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // face_flux[31:0], face_density[62:32], face_area[93:63], inv_distance[124:94],
  // old_value[156:125], older_value[188:157], zero fill
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // reference_value[31:0], value_fraction[48:32], zero fill
  output logic [55:0]  m_tdata,
  // scheme_error
  output logic         m_tuser
);

  localparam int F = FRAC_BITS;
  localparam int DW = 64;  // numerator width of every division

  aoc_pkg::cfg_t cfg;
  logic wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step      <= 31'(64'd1 << F);
      cfg.relax_length   <= '0;
      cfg.far_value      <= '0;
      cfg.time_scheme    <= aoc_pkg::SCHEME_EULER;
      cfg.mass_flux_mode <= 1'b0;
    end else if (wr) begin
      case (paddr[4:2])
        aoc_pkg::REG_TIME_STEP: cfg.time_step      <= pwdata[30:0];
        aoc_pkg::REG_RELAX_LEN: cfg.relax_length   <= pwdata[30:0];
        aoc_pkg::REG_FAR_VALUE: cfg.far_value      <= pwdata;
        aoc_pkg::REG_SCHEME:    cfg.time_scheme    <= pwdata[1:0];
        aoc_pkg::REG_MASS_FLUX: cfg.mass_flux_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      aoc_pkg::REG_TIME_STEP: prdata = {1'b0, cfg.time_step};
      aoc_pkg::REG_RELAX_LEN: prdata = {1'b0, cfg.relax_length};
      aoc_pkg::REG_FAR_VALUE: prdata = cfg.far_value;
      aoc_pkg::REG_SCHEME:    prdata = {30'd0, cfg.time_scheme};
      aoc_pkg::REG_MASS_FLUX: prdata = {31'd0, cfg.mass_flux_mode};
      default:                prdata = '0;
    endcase
  end

  // Global stall: pipeline moves when the output slot is empty or drained.
  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // Side data carried through the pipe
  typedef struct packed {
    logic               err;
    logic               bwd;
    logic               flux_pos;
    logic               den_zero;
    logic [30:0]        invd;
    logic signed [33:0] base;
  } side_t;

  // ---- stage A: unpack, density*area
  logic signed [31:0] i_flux, i_old, i_older;
  logic [30:0] i_rho, i_area, i_invd;
  assign i_flux  = s_tdata[31:0];
  assign i_rho   = s_tdata[62:32];
  assign i_area  = s_tdata[93:63];
  assign i_invd  = s_tdata[124:94];
  assign i_old   = s_tdata[156:125];
  assign i_older = s_tdata[188:157];

  logic a_v;
  side_t a_sd;
  logic [61:0] a_ra;
  logic [30:0] a_area;
  logic signed [31:0] a_flux;
  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= s_tvalid;
    if (en) begin
      a_ra   <= 62'(i_rho) * 62'(i_area);
      a_area <= i_area;
      a_flux <= i_flux;
      a_sd.err  <= cfg.time_scheme[1];
      a_sd.bwd  <= cfg.time_scheme[0];
      a_sd.flux_pos <= !i_flux[31] && (i_flux != 0);
      a_sd.den_zero <= 1'b0;
      a_sd.invd <= i_invd;
      // backward scheme: 2*old - floor(older/2); otherwise old
      a_sd.base <= cfg.time_scheme[0] ?
                   (34'(i_old) <<< 1) - 34'(i_older >>> 1) : 34'(i_old);
    end
  end

  // ---- stage B: pick divisor
  logic b_v;
  side_t b_sd;
  logic [DW-1:0] b_num;
  logic [61:0] b_den;
  always_comb begin
    b_den = cfg.mass_flux_mode ? (a_ra >> F) : 62'(a_area);
  end
  side_t b_sdi;
  always_comb begin
    b_sdi = a_sd;
    b_sdi.den_zero = (b_den == 0);
  end
  assign b_num = DW'({32'd0, a_flux[30:0]}) << F;

  logic d1_v;
  logic [DW-1:0] d1_q;
  side_t d1_sd;
  aoc_divider #(.NUM_W(DW), .DEN_W(62), .SIDE_W($bits(side_t))) u_div_w (
    .clk, .rst, .en, .in_valid(a_v), .num(b_num),
    .den(b_den == 0 ? 62'd1 : b_den), .side_in(b_sdi),
    .out_valid(d1_v), .quot(d1_q), .side_out(d1_sd)
  );
  assign b_v = d1_v;
  assign b_sd = d1_sd;

  // ---- stage C: w, then w*dt
  logic [30:0] w;
  always_comb begin
    if (!b_sd.flux_pos) w = '0;
    else if (b_sd.den_zero || d1_q > DW'(aoc_pkg::SAT31)) w = aoc_pkg::SAT31;
    else w = d1_q[30:0];
  end
  logic c_v;
  side_t c_sd;
  logic [61:0] c_wdt;
  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) c_v <= b_v;
    if (en) begin
      c_wdt <= 62'(w) * 62'(cfg.time_step);
      c_sd  <= b_sd;
    end
  end

  logic [61:0] c_sh;
  logic [30:0] wdt;
  assign c_sh = c_wdt >> F;
  assign wdt  = (c_sh > 62'(aoc_pkg::SAT31)) ? aoc_pkg::SAT31 : c_sh[30:0];

  // ---- stage D: alpha product, launch k division
  logic d_v;
  side_t d_sd;
  logic [61:0] d_al;
  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (en) d_v <= c_v;
    if (en) begin
      d_al <= 62'(wdt) * 62'(c_sd.invd);
      d_sd <= c_sd;
    end
  end

  logic [30:0] d_wdt;
  always_ff @(posedge clk) if (en) d_wdt <= wdt;

  typedef struct packed {
    side_t      s;
    logic [30:0] alpha;
  } side2_t;
  logic [61:0] al_sh;
  side2_t k_in, k_out;
  assign al_sh = d_al >> F;
  always_comb begin
    k_in.s = d_sd;
    k_in.alpha = (al_sh > 62'(aoc_pkg::SAT31)) ? aoc_pkg::SAT31 : al_sh[30:0];
  end
  logic k_v;
  logic [DW-1:0] k_q;
  logic relax_on;
  assign relax_on = cfg.relax_length != 0;
  aoc_divider #(.NUM_W(DW), .DEN_W(31), .SIDE_W($bits(side2_t))) u_div_k (
    .clk, .rst, .en, .in_valid(d_v), .num(DW'(d_wdt) << F),
    .den(relax_on ? cfg.relax_length : 31'd1), .side_in(k_in),
    .out_valid(k_v), .quot(k_q), .side_out(k_out)
  );

  // ---- stage E: ck, numerators (k*far, base*ONE, ck*ONE)
  logic [30:0] k;
  assign k = !relax_on ? '0 :
             (k_q > DW'(aoc_pkg::SAT31)) ? aoc_pkg::SAT31 : k_q[30:0];

  logic e_v;
  side2_t e_sd;
  logic [31:0] e_ck;
  logic signed [63:0] e_kf;
  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (en) e_v <= k_v;
    if (en) begin
      e_ck <= 32'(k) + (k_out.s.bwd ? 32'(64'd3 << (F - 1)) : 32'(64'd1 << F));
      e_kf <= $signed({33'd0, k}) * 64'(cfg.far_value);
      e_sd <= k_out;
    end
  end

  // Three parallel divisions of magnitudes by ck / ck+alpha
  typedef struct packed {
    side2_t      s;
    logic        neg_b;
    logic        neg_k;
  } side3_t;
  side3_t f_in, f_out, g_out, h_out;
  logic signed [63:0] num_b;
  logic [DW-1:0] mag_b, mag_k;
  assign num_b = 64'(e_sd.s.base) <<< F;
  assign mag_b = num_b[63] ? DW'(-num_b) : DW'(num_b);
  assign mag_k = e_kf[63] ? DW'(-e_kf) : DW'(e_kf);
  always_comb begin
    f_in.s = e_sd;
    f_in.neg_b = num_b[63];
    f_in.neg_k = e_kf[63];
  end
  logic f_v, g_v, h_v;
  logic [DW-1:0] qb, qk, qf;
  aoc_divider #(.NUM_W(DW), .DEN_W(32), .SIDE_W($bits(side3_t))) u_div_b (
    .clk, .rst, .en, .in_valid(e_v), .num(mag_b), .den(e_ck), .side_in(f_in),
    .out_valid(f_v), .quot(qb), .side_out(f_out)
  );
  aoc_divider #(.NUM_W(DW), .DEN_W(32), .SIDE_W($bits(side3_t))) u_div_kf (
    .clk, .rst, .en, .in_valid(e_v), .num(mag_k), .den(e_ck), .side_in(f_in),
    .out_valid(g_v), .quot(qk), .side_out(g_out)
  );
  aoc_divider #(.NUM_W(DW), .DEN_W(33), .SIDE_W($bits(side3_t))) u_div_vf (
    .clk, .rst, .en, .in_valid(e_v), .num(DW'(e_ck) << F),
    .den(33'(e_ck) + 33'(e_sd.alpha)), .side_in(f_in),
    .out_valid(h_v), .quot(qf), .side_out(h_out)
  );

  // ---- output stage: signs, sum, saturate
  logic signed [65:0] sb, sk, r;
  assign sb = f_out.neg_b ? -66'(qb) : 66'(qb);
  assign sk = f_out.neg_k ? -66'(qk) : 66'(qk);
  assign r  = sb + sk;
  logic [31:0] r_sat;
  always_comb begin
    if (r > 66'sh7fffffff) r_sat = 32'h7fffffff;
    else if (r < -66'sh80000000) r_sat = 32'h80000000;
    else r_sat = r[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= f_v;
    if (en) begin
      if (f_out.s.s.err) begin
        m_tdata <= '0;
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= {7'd0, qf[16:0], r_sat};
        m_tuser <= 1'b0;
      end
    end
  end

  // Parallel division lanes stay in lockstep
  assert property (@(posedge clk) disable iff (rst)
    f_v == g_v && g_v == h_v && (!f_v || (f_out == g_out && g_out == h_out)))
    else $error("division lanes out of step");
  assert property (@(posedge clk) disable iff (rst)
    f_v && !f_out.s.s.err |-> qf <= DW'(64'd1 << F))
    else $error("value fraction above one");
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result lost while stalled");

endmodule

@@ rtl/aoc_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage, a valid bit and a
// side payload travel with each division. Unsigned operands.
module aoc_divider #(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 40,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quot,
  output logic [SIDE_W-1:0] side_out
);

  logic [NUM_W:0]      vld;
  logic [NUM_W-1:0]    q   [NUM_W+1];
  logic [DEN_W-1:0]    rem [NUM_W+1];
  logic [DEN_W-1:0]    dv  [NUM_W+1];
  logic [SIDE_W-1:0]   sd  [NUM_W+1];

  assign vld[0] = in_valid;
  assign q[0]   = num;
  assign rem[0] = '0;
  assign dv[0]  = den;
  assign sd[0]  = side_in;

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    assign trial = {rem[i], q[i][NUM_W-1]};
    assign diff  = trial - {1'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        if (!diff[DEN_W]) begin
          rem[i+1] <= diff[DEN_W-1:0];
          q[i+1]   <= {q[i][NUM_W-2:0], 1'b1};
        end else begin
          rem[i+1] <= trial[DEN_W-1:0];
          q[i+1]   <= {q[i][NUM_W-2:0], 1'b0};
        end
        dv[i+1] <= dv[i];
        sd[i+1] <= sd[i];
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign quot      = q[NUM_W];
  assign side_out  = sd[NUM_W];

endmodule
